/* rtl/core/phlt_pkg.sv */
// ----------------------------------------------------------------------------
// phlt_pkg
// Shared types and codes for the peer heartbeat liveness table.
// ----------------------------------------------------------------------------
package phlt_pkg;

	// Default number of peer entries in the table.
	localparam int DEFAULT_NUM_PEERS = 8;

	// Register reset values.
	localparam logic [7:0]  OWN_NODE_ID_RESET = 8'd1;
	localparam logic [31:0] TIMEOUT_MS_RESET  = 32'd1000;

	// Input item kinds, carried on the input tuser.
	localparam logic OP_HEARTBEAT = 1'b0;
	localparam logic OP_TICK      = 1'b1;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_OWN_NODE_ID = 1'b0,
		REG_TIMEOUT_MS  = 1'b1
	} cfg_reg_t;

	// Result codes, carried on the output tuser.
	typedef enum logic [2:0] {
		OUT_IGNORED   = 3'd0,
		OUT_UPDATED   = 3'd1,
		OUT_INSERTED  = 3'd2,
		OUT_FULL      = 3'd3,
		OUT_TICK_DONE = 3'd4
	} outcome_t;

	// Item descriptor that walks down the row of entry cells.
	typedef struct packed {
		logic        op;
		logic        ign;
		logic        any_match;
		logic        done;
		logic [7:0]  peer_id;
		logic [7:0]  peer_state;
		logic [7:0]  peer_error;
		logic [7:0]  peer_uptime;
		logic [31:0] now_ms;
		outcome_t    outcome;
		logic [2:0]  slot;
		logic [7:0]  mask;
		logic [31:0] total;
	} tok_t;

endpackage

/* rtl/core/phlt_cell.sv */
// ----------------------------------------------------------------------------
// phlt_cell
// One peer entry of the table. Acts on the item descriptor that reaches it
// and hands the updated descriptor, registered, to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module phlt_cell
	import phlt_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] timeout_ms,
	input  logic [7:0]  bcast_id,
	output logic        hit,
	input  logic        tok_valid_in,
	input  tok_t        tok_in,
	output logic        tok_valid_out,
	output tok_t        tok_out
);

	// Constant contributions of this cell to the result fields.
	localparam logic [2:0] SLOT_CODE = 3'(IDX);
	localparam logic [7:0] MASK_BIT  = (IDX < 8) ? 8'(1 << IDX) : 8'd0;

	logic        active_q;
	logic [7:0]  id_q;
	logic [7:0]  state_q;
	logic [7:0]  error_q;
	logic [7:0]  uptime_q;
	logic [31:0] last_seen_q;
	logic [31:0] rx_count_q;
	logic        valid_q;
	tok_t        tok_q;

	logic [31:0] age;
	logic        expire;
	logic        do_update;
	logic        do_claim;
	tok_t        tok_nxt;

	// Match against the id of the item about to enter the row.
	assign hit = active_q && (id_q == bcast_id);

	// Decide what this entry does with the descriptor.
	always_comb begin
		age       = tok_in.now_ms - last_seen_q;
		expire    = 1'b0;
		do_update = 1'b0;
		do_claim  = 1'b0;
		tok_nxt   = tok_in;
		if (tok_in.op == OP_TICK) begin
			expire = active_q && (age >= timeout_ms);
			if (expire) begin
				tok_nxt.total = tok_in.total + 32'd1;
				tok_nxt.mask  = tok_in.mask | MASK_BIT;
			end
		end else if (!tok_in.ign && !tok_in.done) begin
			if (tok_in.any_match) begin
				do_update = active_q && (id_q == tok_in.peer_id);
			end else begin
				do_claim = !active_q;
			end
			if (do_update || do_claim) begin
				tok_nxt.done    = 1'b1;
				tok_nxt.slot    = SLOT_CODE;
				tok_nxt.outcome = do_update ? OUT_UPDATED : OUT_INSERTED;
			end
		end
	end

	// Entry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			id_q        <= 8'd0;
			state_q     <= 8'd0;
			error_q     <= 8'd0;
			uptime_q    <= 8'd0;
			last_seen_q <= 32'd0;
			rx_count_q  <= 32'd0;
		end else if (tok_valid_in) begin
			if (expire) begin
				active_q <= 1'b0;
				error_q  <= 8'd1;
			end
			if (do_update || do_claim) begin
				active_q    <= 1'b1;
				id_q        <= tok_in.peer_id;
				state_q     <= tok_in.peer_state;
				error_q     <= tok_in.peer_error;
				uptime_q    <= tok_in.peer_uptime;
				last_seen_q <= tok_in.now_ms;
				rx_count_q  <= do_update ? (rx_count_q + 32'd1) : 32'd1;
			end
		end
	end

	// Descriptor register towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid_in) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_valid_out = valid_q;
	assign tok_out       = tok_q;

	// The state and receive count are kept for the peer but not reported.
	logic unused_fields;
	assign unused_fields = ^{state_q, error_q, uptime_q, rx_count_q};

endmodule

/* rtl/core/peer_heartbeat_liveness_table_top.sv */
// ----------------------------------------------------------------------------
// peer_heartbeat_liveness_table_top
// Table of peer nodes refreshed by heartbeats and aged by expiry ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis; tuser selects a heartbeat or an expiry tick
//   and tdata carries the peer fields and the current millisecond time.
//   Every input beat yields exactly one result beat on m_axis: the outcome
//   code on tuser, and slot, expired mask and running expiry total on tdata.
//   Each entry of the table lives in one cell of a row; an accepted item is
//   registered once, then walks the row one cell per cycle into a holding
//   register at its end, and its result then moves on to the output register.
//   One item is in the row at a time: s_axis_tready returns once the result
//   has moved to the output register, so a new item is not taken before
//   the last one has got there.
//   A stalled m_axis holds its result; the next item can still enter and
//   walk the row, and waits in a holding register at the end of it.
//   Reset empties the table, clears the expiry total and loads the
//   registers with own id 1 and timeout 1000 ms. Registers are written
//   through cfg_we / cfg_idx / cfg_wdata; the user must write them only
//   while no item is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module peer_heartbeat_liveness_table_top
	import phlt_pkg::*;
#(
	parameter int NUM_PEERS = DEFAULT_NUM_PEERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] peer_id, [15:8] peer_state, [23:16] peer_error,
	// [31:24] peer_uptime, [63:32] now_ms
	input  logic [63:0] s_axis_tdata,
	// [0] opcode
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] slot, [10:3] expired_mask, [42:11] expired_total, [47:43] zero
	output logic [47:0] m_axis_tdata,
	// [2:0] outcome
	output logic [2:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic        accept;
	logic        busy_q;
	logic        out_free;
	logic        pend_move;

	logic [7:0]  own_id_q;
	logic [31:0] timeout_q;
	logic [31:0] expire_cnt_q;

	logic        in_valid_q;
	logic        in_op_q;
	logic [7:0]  in_id_q;
	logic [7:0]  in_state_q;
	logic [7:0]  in_error_q;
	logic [7:0]  in_uptime_q;
	logic [31:0] in_now_q;

	logic [NUM_PEERS-1:0] hit;
	logic                 tok_v [0:NUM_PEERS];
	tok_t                 toks  [0:NUM_PEERS];
	logic [NUM_PEERS+1:0] vld_vec;

	logic        pend_valid_q;
	tok_t        pend_q;
	logic        m_valid_q;
	outcome_t    m_outcome_q;
	logic [2:0]  m_slot_q;
	logic [7:0]  m_mask_q;
	logic [31:0] m_total_q;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign pend_move     = pend_valid_q && out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= OWN_NODE_ID_RESET;
			timeout_q <= TIMEOUT_MS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_OWN_NODE_ID: own_id_q  <= cfg_wdata[7:0];
				REG_TIMEOUT_MS:  timeout_q <= cfg_wdata;
				default:         own_id_q  <= own_id_q;
			endcase
		end
	end

	// One item in flight from accept until its result reaches the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			in_valid_q <= 1'b0;
		end else begin
			in_valid_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (pend_move) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_op_q     <= s_axis_tuser;
			in_id_q     <= s_axis_tdata[7:0];
			in_state_q  <= s_axis_tdata[15:8];
			in_error_q  <= s_axis_tdata[23:16];
			in_uptime_q <= s_axis_tdata[31:24];
			in_now_q    <= s_axis_tdata[63:32];
		end
	end

	// Build the descriptor that enters the first cell.
	always_comb begin
		tok_v[0]               = in_valid_q;
		toks[0].op             = in_op_q;
		toks[0].ign            = (in_id_q == own_id_q) || (in_id_q == 8'd0);
		toks[0].any_match      = |hit;
		toks[0].done           = 1'b0;
		toks[0].peer_id        = in_id_q;
		toks[0].peer_state     = in_state_q;
		toks[0].peer_error     = in_error_q;
		toks[0].peer_uptime    = in_uptime_q;
		toks[0].now_ms         = in_now_q;
		toks[0].slot           = 3'd0;
		toks[0].mask           = 8'd0;
		toks[0].total          = expire_cnt_q;
		if (in_op_q == OP_TICK) begin
			toks[0].outcome = OUT_TICK_DONE;
		end else if (toks[0].ign) begin
			toks[0].outcome = OUT_IGNORED;
		end else begin
			toks[0].outcome = OUT_FULL;
		end
	end

	// Row of entry cells.
	for (genvar i = 0; i < NUM_PEERS; i++) begin : g_cell
		phlt_cell #(
			.IDX(i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.timeout_ms    (timeout_q),
			.bcast_id      (in_id_q),
			.hit           (hit[i]),
			.tok_valid_in  (tok_v[i]),
			.tok_in        (toks[i]),
			.tok_valid_out (tok_v[i+1]),
			.tok_out       (toks[i+1])
		);
	end

	// Holding register at the end of the row, and the expiry total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			expire_cnt_q <= 32'd0;
		end else begin
			if (tok_v[NUM_PEERS]) begin
				pend_valid_q <= 1'b1;
				expire_cnt_q <= toks[NUM_PEERS].total;
			end else if (pend_move) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_v[NUM_PEERS]) begin
			pend_q <= toks[NUM_PEERS];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pend_move) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			m_outcome_q <= pend_q.outcome;
			m_slot_q    <= pend_q.slot;
			m_mask_q    <= pend_q.mask;
			m_total_q   <= pend_q.total;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_outcome_q;
	assign m_axis_tdata  = {5'd0, m_total_q, m_mask_q, m_slot_q};

	// Occupancy of the walk, from the input register to the holding register.
	always_comb begin
		vld_vec[0]           = in_valid_q;
		vld_vec[NUM_PEERS+1] = pend_valid_q;
		for (int k = 1; k <= NUM_PEERS; k++) begin
			vld_vec[k] = tok_v[k];
		end
	end

	// At most one item is ever travelling through the row.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(vld_vec))
		else $error("more than one item in the entry row");

	// Nothing travels through the row unless an item is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) !busy_q |-> (vld_vec == '0))
		else $error("item in the row while the block is idle");

	// An accepted beat closes the input until its result reaches the output register.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !s_axis_tready)
		else $error("input reopened while an item is in flight");

	// Heartbeat results never report expired entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_outcome_q != OUT_TICK_DONE)) |-> (m_mask_q == 8'd0))
		else $error("expired mask set on a heartbeat result");

endmodule
